// File: design/flpm_pkg.sv
package flpm_pkg;

  // defaults for the top-level parameters
  localparam int DEFAULT_NUM_FAULTS  = 6;
  localparam int DEFAULT_COUNT_WIDTH = 16;

  // fixed field widths
  localparam int OPCODE_W = 2;
  localparam int INDEX_W  = 4;
  localparam int THRESH_W = 16;
  localparam int MASK_W   = 6;
  localparam int TOTAL_W  = 3;
  localparam int OCC_W    = 16;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd10;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  // event broadcast to every cell
  typedef struct packed {
    logic               fire;
    logic               set;
    logic               clear;
    logic               tick;
    logic [INDEX_W-1:0] index;
  } evt_t;

  // one result word
  typedef struct packed {
    logic               index_invalid;
    logic [MASK_W-1:0]  new_persistent_mask;
    logic [OCC_W-1:0]   occurrence_count;
    logic [TOTAL_W-1:0] persistent_total;
    logic [TOTAL_W-1:0] active_total;
    logic [MASK_W-1:0]  persistent_mask;
    logic [MASK_W-1:0]  active_mask;
  } res_t;

endpackage

// File: design/flpm_cell.sv
module flpm_cell #(
  parameter int CELL_IDX    = 0,
  parameter int COUNT_WIDTH = flpm_pkg::DEFAULT_COUNT_WIDTH,
  parameter int SUM_W       = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  flpm_pkg::evt_t                evt,
  input  logic [flpm_pkg::THRESH_W-1:0] threshold,
  input  logic [flpm_pkg::OCC_W-1:0]    occ_in,
  input  logic [SUM_W-1:0]              act_sum_in,
  input  logic [SUM_W-1:0]              per_sum_in,
  output logic [flpm_pkg::OCC_W-1:0]    occ_out,
  output logic [SUM_W-1:0]              act_sum_out,
  output logic [SUM_W-1:0]              per_sum_out,
  output logic                          act_bit,
  output logic                          per_bit,
  output logic                          fresh_bit
);

  logic                   act;
  logic                   per;
  logic [COUNT_WIDTH-1:0] occ;
  logic [COUNT_WIDTH-1:0] tcnt;
  logic                   act_next;
  logic                   per_next;
  logic [COUNT_WIDTH-1:0] occ_next;
  logic [COUNT_WIDTH-1:0] tcnt_next;
  logic                   fresh;
  logic                   hit;
  logic [31:0]            occ_wide;

  assign hit = (evt.index == flpm_pkg::INDEX_W'(CELL_IDX));

  always_comb begin
    act_next  = act;
    per_next  = per;
    occ_next  = occ;
    tcnt_next = tcnt;
    fresh     = 1'b0;
    if (evt.set && hit && !act) begin
      act_next = 1'b1;
      occ_next = (occ == '1) ? occ : occ + COUNT_WIDTH'(1);
    end
    if (evt.clear && hit) begin
      act_next = 1'b0;
    end
    if (evt.tick) begin
      if (act) begin
        tcnt_next = (tcnt == '1) ? tcnt : tcnt + COUNT_WIDTH'(1);
        if ((32'(tcnt_next) >= 32'(threshold)) && !per) begin
          per_next = 1'b1;
          fresh    = 1'b1;
        end
      end else begin
        tcnt_next = '0;
        per_next  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act  <= 1'b0;
      per  <= 1'b0;
      occ  <= '0;
      tcnt <= '0;
    end else if (evt.fire) begin
      act  <= act_next;
      per  <= per_next;
      occ  <= occ_next;
      tcnt <= tcnt_next;
    end
  end

  // addressed cell replaces the count travelling down the row
  assign occ_wide    = 32'(occ_next);
  assign occ_out     = (hit && (evt.set || evt.clear)) ? occ_wide[flpm_pkg::OCC_W-1:0] : occ_in;
  assign act_sum_out = act_sum_in + SUM_W'(act_next);
  assign per_sum_out = per_sum_in + SUM_W'(per_next);
  assign act_bit     = act_next;
  assign per_bit     = per_next;
  assign fresh_bit   = fresh;

endmodule

// File: design/flpm_outbuf.sv
module flpm_outbuf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  flpm_pkg::res_t push_data,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output flpm_pkg::res_t head_data
);

  logic [1:0]     count;
  flpm_pkg::res_t head;
  flpm_pkg::res_t tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case (count)
        2'd0: begin
          if (push) begin
            count <= 2'd1;
          end
        end
        2'd1: begin
          if (push && !pop) begin
            count <= 2'd2;
          end else if (!push && pop) begin
            count <= 2'd0;
          end
        end
        default: begin
          if (pop) begin
            count <= 2'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (count)
      2'd0: begin
        if (push) begin
          head <= push_data;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head <= push_data;
        end else if (push) begin
          tail <= push_data;
        end
      end
      default: begin
        if (pop) begin
          head <= tail;
        end
      end
    endcase
  end

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head_data = head;

endmodule

// File: design/fault_latch_persistence_monitor.sv
// Fault monitor with one active flag, one persistent flag, a saturating
// occurrence counter and a saturating persistence counter per fault type.
// Events arrive on the s_ stream (opcode in tuser: set, clear or tick) and
// each event returns exactly one result word on the m_ stream, showing
// the state after the event. One event can be taken every clock cycle:
// all fault cells update in the same cycle and the result is registered
// into a two-word output buffer, so s_tready drops only when both words
// are held by a stalled consumer. The persistence threshold is to be
// written over the cfg_ port while no event is in flight, which the block
// itself does not enforce; it resets to 10 and a value of 0 behaves as 1.
module fault_latch_persistence_monitor #(
  parameter int NUM_FAULTS  = flpm_pkg::DEFAULT_NUM_FAULTS,
  parameter int COUNT_WIDTH = flpm_pkg::DEFAULT_COUNT_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: persist_threshold
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // event stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [3:0] fault_index, [7:4] zero
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [5:0] active_mask, [11:6] persistent_mask,
                                 // [14:12] active_total, [17:15] persistent_total,
                                 // [33:18] occurrence_count,
                                 // [39:34] new_persistent_mask
  output logic        m_tuser    // [0] index_invalid
);

  localparam int SUM_W = $clog2(NUM_FAULTS + 1);

  logic [flpm_pkg::THRESH_W-1:0] threshold;
  logic                          accept;
  logic                          full;
  flpm_pkg::op_t                 op;
  logic [flpm_pkg::INDEX_W-1:0]  index;
  logic                          bad_index;
  logic                          addr_op;
  flpm_pkg::evt_t                evt;
  flpm_pkg::res_t                res;
  flpm_pkg::res_t                head;

  // chain between cells: occurrence select and running totals
  logic [flpm_pkg::OCC_W-1:0] occ_chain [0:NUM_FAULTS];
  logic [SUM_W-1:0]           act_chain [0:NUM_FAULTS];
  logic [SUM_W-1:0]           per_chain [0:NUM_FAULTS];
  logic [NUM_FAULTS-1:0]      act_vec;
  logic [NUM_FAULTS-1:0]      per_vec;
  logic [NUM_FAULTS-1:0]      fresh_vec;

  logic [15:0] act_wide;
  logic [15:0] per_wide;
  logic [15:0] fresh_wide;
  logic [7:0]  act_tot_wide;
  logic [7:0]  per_tot_wide;

  // threshold register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= flpm_pkg::THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;
  assign op       = flpm_pkg::op_t'(s_tuser);
  assign index    = s_tdata[flpm_pkg::INDEX_W-1:0];

  // set or clear naming a fault beyond the row is flagged and changes nothing
  always_comb begin
    case (op)
      flpm_pkg::OP_SET, flpm_pkg::OP_CLEAR: addr_op = 1'b1;
      default:                              addr_op = 1'b0;
    endcase
  end

  assign bad_index = addr_op && ({1'b0, index} >= (flpm_pkg::INDEX_W + 1)'(NUM_FAULTS));

  assign evt.fire  = accept;
  assign evt.set   = (op == flpm_pkg::OP_SET);
  assign evt.clear = (op == flpm_pkg::OP_CLEAR);
  assign evt.tick  = (op == flpm_pkg::OP_TICK);
  assign evt.index = index;

  assign occ_chain[0] = '0;
  assign act_chain[0] = '0;
  assign per_chain[0] = '0;

  for (genvar k = 0; k < NUM_FAULTS; k++) begin : g_cell
    flpm_cell #(
      .CELL_IDX    (k),
      .COUNT_WIDTH (COUNT_WIDTH),
      .SUM_W       (SUM_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .evt         (evt),
      .threshold   (threshold),
      .occ_in      (occ_chain[k]),
      .act_sum_in  (act_chain[k]),
      .per_sum_in  (per_chain[k]),
      .occ_out     (occ_chain[k+1]),
      .act_sum_out (act_chain[k+1]),
      .per_sum_out (per_chain[k+1]),
      .act_bit     (act_vec[k]),
      .per_bit     (per_vec[k]),
      .fresh_bit   (fresh_vec[k])
    );
  end

  // masks and totals cut to the output field widths
  assign act_wide     = 16'(act_vec);
  assign per_wide     = 16'(per_vec);
  assign fresh_wide   = 16'(fresh_vec);
  assign act_tot_wide = 8'(act_chain[NUM_FAULTS]);
  assign per_tot_wide = 8'(per_chain[NUM_FAULTS]);

  assign res.active_mask         = act_wide[flpm_pkg::MASK_W-1:0];
  assign res.persistent_mask     = per_wide[flpm_pkg::MASK_W-1:0];
  assign res.active_total        = act_tot_wide[flpm_pkg::TOTAL_W-1:0];
  assign res.persistent_total    = per_tot_wide[flpm_pkg::TOTAL_W-1:0];
  assign res.occurrence_count    = occ_chain[NUM_FAULTS];
  assign res.new_persistent_mask = fresh_wide[flpm_pkg::MASK_W-1:0];
  assign res.index_invalid       = bad_index;

  flpm_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .pop       (m_tvalid && m_tready),
    .full      (full),
    .not_empty (m_tvalid),
    .head_data (head)
  );

  assign m_tdata = {head.new_persistent_mask, head.occurrence_count, head.persistent_total,
                    head.active_total, head.persistent_mask, head.active_mask};
  assign m_tuser = head.index_invalid;

endmodule
